FILE: rtl/tdvt_pkg.sv
// Shared types and constants for the tolerance dedup vector table.
package tdvt_pkg;

  localparam int MaxEntries = 64;
  localparam int MaxDim = 16;
  localparam int EntW = $clog2(MaxEntries);
  localparam int DimW = $clog2(MaxDim);
  localparam int CntW = $clog2(MaxEntries + 1);
  localparam int CoordW = 48;
  localparam int TolW = 33;
  localparam int MemW = EntW + DimW;

  localparam logic [1:0] CMD_INS_NEW = 2'd0;
  localparam logic [1:0] CMD_INS_ALW = 2'd1;
  localparam logic [1:0] CMD_COUNT = 2'd2;
  localparam logic [1:0] CMD_OVERWR = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BADIDX = 2'd2;

  localparam logic CFG_VLEN = 1'b0;
  localparam logic CFG_TOL = 1'b1;

  typedef struct packed {
    logic [1:0] cmd;
    logic [5:0] entry_index;
    logic signed [CoordW-1:0] coord_real;
    logic signed [CoordW-1:0] coord_imag;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic added;
    logic [6:0] match_count;
    logic [6:0] stored_count;
    logic [5:0] slot;
  } out_word_t;

  // queued coordinate: word plus its position and completion flag
  typedef struct packed {
    in_word_t w;
    logic [DimW-1:0] pos;
    logic last;
  } job_t;

endpackage

FILE: rtl/tdvt_front.sv
// Front end: tracks coordinate position and queues coordinate jobs.
module tdvt_front (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  tdvt_pkg::in_word_t in_word,
  input  logic [4:0] vlen,
  input  logic q_full,
  output logic busy,
  output logic push,
  output tdvt_pkg::job_t push_job
);
  logic [tdvt_pkg::DimW-1:0] pos_r, pos_nxt;
  logic [4:0] alen;
  logic last;

  always_comb begin
    if (vlen == 5'd0) alen = 5'd1;
    else if (vlen > 5'(tdvt_pkg::MaxDim)) alen = 5'(tdvt_pkg::MaxDim);
    else alen = vlen;
  end

  assign busy = q_full;
  assign push = start && !q_full;
  assign last = (5'(pos_r) + 5'd1) >= alen;
  assign push_job = '{w: in_word, pos: pos_r, last: last};

  always_comb begin
    pos_nxt = pos_r;
    if (push) pos_nxt = last ? '0 : pos_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) pos_r <= '0;
    else pos_r <= pos_nxt;
  end
endmodule

FILE: rtl/tdvt_fifo.sv
// Two-entry queue between front and back.
module tdvt_fifo (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  tdvt_pkg::job_t din,
  input  logic pop,
  output logic full,
  output logic empty,
  output tdvt_pkg::job_t dout
);
  tdvt_pkg::job_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign dout = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule

FILE: rtl/tdvt_back.sv
// Back end: scans stored entries per coordinate and executes commands.
module tdvt_back (
  input  logic clk,
  input  logic rst_n,
  input  logic [tdvt_pkg::TolW-1:0] tol,
  input  logic q_empty,
  input  tdvt_pkg::job_t job,
  output logic pop,
  output logic out_strobe,
  output tdvt_pkg::out_word_t out_word
);
  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_CMP, S_EXEC, S_COPY, S_CWR} state_t;

  localparam int CW = tdvt_pkg::CoordW;

  state_t state_r;
  logic [2*CW-1:0] store [2**tdvt_pkg::MemW];
  logic [2*CW-1:0] inc [tdvt_pkg::MaxDim];
  logic [2*CW-1:0] rd_r, crd_r;
  logic [tdvt_pkg::MaxEntries-1:0] mis_r;
  logic [tdvt_pkg::CntW-1:0] tot_r, e_r, mc_r;
  logic [tdvt_pkg::EntW-1:0] ent_r, rde_r;
  logic [tdvt_pkg::DimW-1:0] d_r, dlast_r;
  logic [tdvt_pkg::DimW-1:0] cd_r;
  logic cv_r;
  tdvt_pkg::job_t j_r;
  tdvt_pkg::out_word_t ow_r;
  logic ostb_r;
  logic far;
  logic signed [CW:0] dr, di;
  logic [CW:0] ar, ai;

  assign out_strobe = ostb_r;
  assign out_word = ow_r;
  assign pop = (state_r == S_IDLE) && !q_empty;

  always_comb begin
    dr = {rd_r[2*CW-1], rd_r[2*CW-1:CW]} - {j_r.w.coord_real[CW-1], j_r.w.coord_real};
    di = {rd_r[CW-1], rd_r[CW-1:0]} - {j_r.w.coord_imag[CW-1], j_r.w.coord_imag};
    ar = dr[CW] ? -dr : dr;
    ai = di[CW] ? -di : di;
    far = (ar > (CW+1)'(tol)) || (ai > (CW+1)'(tol));
  end

  always_ff @(posedge clk) begin
    rd_r <= store[{rde_r, j_r.pos}];
    crd_r <= inc[cd_r];
    if (cv_r) store[{ent_r, dlast_r}] <= crd_r;
    if (pop) inc[job.pos] <= {job.w.coord_real, job.w.coord_imag};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mis_r <= '0;
      tot_r <= '0;
      ostb_r <= 1'b0;
      cv_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          ostb_r <= 1'b0;
          cv_r <= 1'b0;
          if (pop) begin
            j_r <= job;
            e_r <= '0;
            rde_r <= '0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          ostb_r <= 1'b0;
          cv_r <= 1'b0;
          if (e_r >= tot_r) begin
            state_r <= S_EXEC;
            mc_r <= '0;
            e_r <= '0;
          end else begin
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          ostb_r <= 1'b0;
          cv_r <= 1'b0;
          if (far) mis_r[rde_r] <= 1'b1;
          e_r <= e_r + 1'b1;
          rde_r <= rde_r + 1'b1;
          state_r <= S_SCAN;
        end
        S_EXEC: begin
          cv_r <= 1'b0;
          if (!j_r.last) begin
            ostb_r <= 1'b0;
            state_r <= S_IDLE;
          end else if (e_r < tot_r) begin
            ostb_r <= 1'b0;
            if (!mis_r[e_r[tdvt_pkg::EntW-1:0]]) mc_r <= mc_r + 1'b1;
            e_r <= e_r + 1'b1;
          end else begin
            mis_r <= '0;
            case (j_r.w.cmd)
              tdvt_pkg::CMD_INS_NEW, tdvt_pkg::CMD_INS_ALW: begin
                if (j_r.w.cmd == tdvt_pkg::CMD_INS_NEW && mc_r != '0) begin
                  ow_r <= '{status: tdvt_pkg::ST_OK, added: 1'b0, match_count: mc_r,
                            stored_count: tot_r, slot: '0};
                  ostb_r <= 1'b1;
                  state_r <= S_IDLE;
                end else if (tot_r >= tdvt_pkg::CntW'(tdvt_pkg::MaxEntries)) begin
                  ow_r <= '{status: tdvt_pkg::ST_FULL, added: 1'b0, match_count: '0,
                            stored_count: tot_r, slot: '0};
                  ostb_r <= 1'b1;
                  state_r <= S_IDLE;
                end else begin
                  ow_r <= '{status: tdvt_pkg::ST_OK, added: 1'b1, match_count: '0,
                            stored_count: tot_r + 1'b1,
                            slot: tot_r[tdvt_pkg::EntW-1:0]};
                  ostb_r <= 1'b0;
                  ent_r <= tot_r[tdvt_pkg::EntW-1:0];
                  tot_r <= tot_r + 1'b1;
                  cd_r <= '0;
                  state_r <= S_COPY;
                end
              end
              tdvt_pkg::CMD_COUNT: begin
                ow_r <= '{status: tdvt_pkg::ST_OK, added: 1'b0, match_count: mc_r,
                          stored_count: tot_r, slot: '0};
                ostb_r <= 1'b1;
                state_r <= S_IDLE;
              end
              default: begin
                if (tdvt_pkg::CntW'(j_r.w.entry_index) >= tot_r) begin
                  ow_r <= '{status: tdvt_pkg::ST_BADIDX, added: 1'b0, match_count: '0,
                            stored_count: tot_r, slot: '0};
                  ostb_r <= 1'b1;
                  state_r <= S_IDLE;
                end else begin
                  ow_r <= '{status: tdvt_pkg::ST_OK, added: 1'b1, match_count: '0,
                            stored_count: tot_r, slot: j_r.w.entry_index};
                  ostb_r <= 1'b0;
                  ent_r <= j_r.w.entry_index;
                  cd_r <= '0;
                  state_r <= S_COPY;
                end
              end
            endcase
          end
        end
        S_COPY: begin
          ostb_r <= 1'b0;
          cv_r <= 1'b1;
          dlast_r <= cd_r;
          if (cd_r == j_r.pos) state_r <= S_CWR;
          else cd_r <= cd_r + 1'b1;
        end
        S_CWR: begin
          ostb_r <= 1'b1;
          cv_r <= 1'b0;
          state_r <= S_IDLE;
        end
        default: begin
          ostb_r <= 1'b0;
          cv_r <= 1'b0;
          state_r <= S_IDLE;
        end
      endcase
    end
  end
endmodule

FILE: rtl/tolerance_dedup_vector_table.sv
// Top level of the tolerance dedup vector table.
// Each coordinate word is checked against every stored entry by a per-entry scan of the
// coordinate memory (S_SCAN, then S_CMP); a two-word queue lets start be taken meanwhile.
// A completing word adds match counting over the stored entries and, on a write, a copy of
// each coordinate into the table; the result strobe is registered and cannot be stalled.
// Synchronous active-low reset empties the table; no clearing pass.
module tolerance_dedup_vector_table (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  tdvt_pkg::in_word_t in_word,
  output logic out_strobe,
  output tdvt_pkg::out_word_t out_word,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [tdvt_pkg::TolW-1:0] cfg_data
);
  logic [4:0] vlen_r;
  logic [tdvt_pkg::TolW-1:0] tol_r;
  logic q_full, q_empty, push, pop;
  tdvt_pkg::job_t push_job, pop_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vlen_r <= 5'd16;
      tol_r <= tdvt_pkg::TolW'(4295);
    end else if (cfg_we) begin
      if (cfg_index == tdvt_pkg::CFG_VLEN) vlen_r <= cfg_data[4:0];
      else tol_r <= cfg_data;
    end
  end

  tdvt_front u_front (.clk, .rst_n, .start, .in_word, .vlen(vlen_r), .q_full,
                      .busy, .push, .push_job);
  tdvt_fifo u_fifo (.clk, .rst_n, .push, .din(push_job), .pop, .full(q_full),
                    .empty(q_empty), .dout(pop_job));
  tdvt_back u_back (.clk, .rst_n, .tol(tol_r), .q_empty, .job(pop_job), .pop,
                    .out_strobe, .out_word);
endmodule
